@@ sv/vtm4_pkg.sv @@
// Shared types and helpers for the 4x4 matrix / 4-vector transform.
// No dependencies; imported by vtm4_cell and vertex_transform_mat4_vec4.
package vtm4_pkg;

  localparam int COMP_W = 32;
  localparam int PROD_W = 2 * COMP_W;
  // Four shifted 64-bit products summed exactly.
  localparam int SUM_W  = PROD_W + 2;
  localparam int NCOMP  = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } opcode_t;

  // One request as it walks down the cell chain.
  typedef struct packed {
    logic                                valid;
    opcode_t                             opcode;
    logic [1:0]                          column_index;
    logic [NCOMP-1:0][COMP_W-1:0]        vec;
    logic [NCOMP-1:0][SUM_W-1:0]         sums;
  } tok_t;

  // Clip a row sum to 32 bits; MSB of the result is the clip flag.
  function automatic logic [COMP_W:0] sat32(input logic [SUM_W-1:0] s);
    logic [COMP_W:0] res;
    if ((&s[SUM_W-1:COMP_W-1]) || !(|s[SUM_W-1:COMP_W-1])) begin
      res = {1'b0, s[COMP_W-1:0]};
    end else if (s[SUM_W-1]) begin
      res = {1'b1, 1'b1, {(COMP_W-1){1'b0}}};
    end else begin
      res = {1'b1, 1'b0, {(COMP_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

@@ sv/vertex_transform_mat4_vec4.sv @@
// Top level of the 4x4 matrix times 4-vector transform, signed Q16.16.
// Depends on vtm4_pkg and vtm4_cell.
//
// A request either loads one matrix column (opcode 0, no result) or
// transforms a vector (opcode 1, one result: four saturated row dot
// products plus a clip flag). One request is taken per clock when the
// result side is not stalled; with no stalls a result reaches the outputs
// through nine register stages (four cells of two stages each plus the
// output register, the first of which loads on the edge that takes its
// request). The chain is four cells, one per matrix column, each with
// four 32x32 multipliers, so sixteen products are in
// flight at once. Loads flow down the chain like vectors, so a vector
// always sees exactly the columns loaded before it. The matrix resets to
// identity. The whole chain stalls together while a finished result waits
// to be taken.
module vertex_transform_mat4_vec4 import vtm4_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               opcode,
  input  logic [1:0]         column_index,
  input  logic signed [31:0] comp_x,
  input  logic signed [31:0] comp_y,
  input  logic signed [31:0] comp_z,
  input  logic signed [31:0] comp_w,
  // result side
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic               saturated
);

  tok_t            chain [NCOMP+1];
  logic            adv;
  logic [COMP_W:0] clip [NCOMP];

  // Chain moves whenever the output register is free or being emptied.
  assign adv       = !res_valid || !res_stall;
  assign req_stall = !adv;

  always_comb begin
    chain[0].valid        = req_valid;
    chain[0].opcode       = opcode_t'(opcode);
    chain[0].column_index = column_index;
    chain[0].vec          = {comp_w, comp_z, comp_y, comp_x};
    chain[0].sums         = '0;
  end

  for (genvar c = 0; c < NCOMP; c++) begin : g_cell
    vtm4_cell #(
      .COL       (c),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (chain[c]),
      .tok_out (chain[c+1])
    );
  end

  always_comb begin
    for (int r = 0; r < NCOMP; r++) begin
      clip[r] = sat32(chain[NCOMP].sums[r]);
    end
  end

  // Output register: only transforms produce a result; loads drop here.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= chain[NCOMP].valid && chain[NCOMP].opcode == OP_XFORM;
      out_x     <= clip[0][COMP_W-1:0];
      out_y     <= clip[1][COMP_W-1:0];
      out_z     <= clip[2][COMP_W-1:0];
      out_w     <= clip[3][COMP_W-1:0];
      saturated <= clip[0][COMP_W] | clip[1][COMP_W] | clip[2][COMP_W] | clip[3][COMP_W];
    end
  end

  // A set clip flag means at least one component sits at a rail.
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    res_valid && saturated |->
      (out_x == 32'sh7FFFFFFF || out_x == 32'sh80000000 ||
       out_y == 32'sh7FFFFFFF || out_y == 32'sh80000000 ||
       out_z == 32'sh7FFFFFFF || out_z == 32'sh80000000 ||
       out_w == 32'sh7FFFFFFF || out_w == 32'sh80000000))
    else $error("clip flag without a clipped component");

  // A transform leaving the chain must land in the output register.
  a_xform_out: assert property (@(posedge clk) disable iff (rst)
    adv && chain[NCOMP].valid && chain[NCOMP].opcode == OP_XFORM |=> res_valid)
    else $error("transform result lost at output");

  // A load leaving the chain never produces a result.
  a_load_drop: assert property (@(posedge clk) disable iff (rst)
    adv && !(chain[NCOMP].valid && chain[NCOMP].opcode == OP_XFORM) |=> !res_valid)
    else $error("result without a transform");

  // Requests are held off only while a result waits on a stalled sink.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request side stalled without cause");

endmodule

@@ sv/vtm4_cell.sv @@
// One chain cell: owns one matrix column, multiplies it by its vector
// component and adds into the running row sums. Depends on vtm4_pkg.
module vtm4_cell import vtm4_pkg::*; #(
  parameter int COL       = 0,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  tok_t tok_in,
  output tok_t tok_out
);

  logic signed [COMP_W-1:0] col_reg [NCOMP];
  logic signed [PROD_W-1:0] prod    [NCOMP];
  tok_t                     mid;
  tok_t                     last;
  tok_t                     last_next;

  // Column update happens as the load passes; later requests see it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NCOMP; r++) begin
        col_reg[r] <= (r == COL) ? (32'sd1 <<< FRAC_BITS) : '0;
      end
    end else if (adv && tok_in.valid && tok_in.opcode == OP_LOAD &&
                 tok_in.column_index == 2'(COL)) begin
      for (int r = 0; r < NCOMP; r++) begin
        col_reg[r] <= $signed(tok_in.vec[r]);
      end
    end
  end

  // Stage B sums: shifted products folded into the passing request.
  always_comb begin
    last_next = mid;
    for (int r = 0; r < NCOMP; r++) begin
      last_next.sums[r] = $signed(mid.sums[r]) + SUM_W'(prod[r] >>> FRAC_BITS);
    end
  end

  // Stage A: products. Stage B: accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid  <= 1'b0;
      last.valid <= 1'b0;
    end else if (adv) begin
      mid  <= tok_in;
      for (int r = 0; r < NCOMP; r++) begin
        prod[r] <= $signed(tok_in.vec[COL]) * col_reg[r];
      end
      last <= last_next;
    end
  end

  assign tok_out = last;

endmodule
